// ===== hdl/sbt_pkg.sv =====
// sbt_pkg: shared types, character codes and widths for the s-expression tokenizer
// no dependencies; imported by every module of the block

package sbt_pkg;

    localparam int TOKEN_LIMIT_W         = 11;
    localparam int TOKEN_COUNT_W         = 11;
    localparam int DEF_MAX_TOKEN_CHARS   = 64;
    localparam int DEF_MAX_TOKENS        = 1024;
    localparam int DEF_QUEUE_DEPTH       = 4;
    localparam int RUN_MAX               = 4;
    localparam int RUN_W                 = $clog2(RUN_MAX + 1);

    localparam logic [TOKEN_LIMIT_W-1:0] TOKEN_LIMIT_RESET = 11'd1024;

    // character codes
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LESS    = 8'h3C;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_GREATER = 8'h3E;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;

    typedef enum logic [2:0] {
        SM_IDLE,
        SM_SYM,
        SM_STR,
        SM_SLASH,
        SM_COMMENT,
        SM_FAILED
    } scan_mode_t;

    typedef enum logic [1:0] {
        EV_BYTE,
        EV_CLOSE,
        EV_ERROR,
        EV_DONE
    } event_kind_t;

    typedef enum logic [2:0] {
        TK_LPAREN,
        TK_RPAREN,
        TK_NUMBER,
        TK_SYMBOL,
        TK_STRING
    } token_kind_t;

    typedef enum logic [2:0] {
        ERR_UNCLOSED,
        ERR_STRING_LONG,
        ERR_TOKEN_LONG,
        ERR_UNKNOWN,
        ERR_TOO_MANY
    } error_code_t;

    typedef enum logic [3:0] {
        CC_SPACE,
        CC_NEWLINE,
        CC_LPAREN,
        CC_RPAREN,
        CC_QUOTE,
        CC_SLASH,
        CC_DIGIT,
        CC_WORD,
        CC_BAD
    } char_class_t;

    typedef struct packed {
        logic [7:0] src_byte;
        logic       end_of_source;
    } src_word_t;

    typedef struct packed {
        logic [1:0]               event_kind;
        logic [2:0]               token_kind;
        logic [7:0]               token_char;
        logic                     is_first;
        logic                     closes_token;
        logic [2:0]               error_code;
        logic [TOKEN_COUNT_W-1:0] token_count;
        logic                     last_of_run;
    } res_word_t;

    // classified source word as held in the queue
    typedef struct packed {
        logic [7:0]  ch;
        char_class_t cls;
        logic        eos;
    } cls_word_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ===== hdl/sbt_front.sv =====
// sbt_front: accepts source words and classifies each byte
// depends on sbt_pkg; feeds sbt_queue

module sbt_front
    import sbt_pkg::*;
(
    input  logic      src_valid,
    output logic      src_stall,
    input  src_word_t src_word,
    input  q_status_t q_stat,
    output logic      push,
    output cls_word_t push_word
);

    char_class_t cls;

    always_comb
    begin
        if (src_word.src_byte == CH_NEWLINE)
            cls = CC_NEWLINE;
        else if (src_word.src_byte inside {[CH_TAB:CH_CR], CH_SPACE})
            cls = CC_SPACE;
        else if (src_word.src_byte == CH_LPAREN)
            cls = CC_LPAREN;
        else if (src_word.src_byte == CH_RPAREN)
            cls = CC_RPAREN;
        else if (src_word.src_byte == CH_QUOTE)
            cls = CC_QUOTE;
        else if (src_word.src_byte == CH_SLASH)
            cls = CC_SLASH;
        else if (src_word.src_byte inside {[CH_ZERO:CH_NINE]})
            cls = CC_DIGIT;
        else if (src_word.src_byte inside {[CH_UPPER_A:CH_UPPER_Z], [CH_LOWER_A:CH_LOWER_Z],
                                           CH_PLUS, CH_MINUS, CH_STAR, CH_EQUAL, CH_LESS,
                                           CH_GREATER, CH_AMP, CH_BANG})
            cls = CC_WORD;
        else
            cls = CC_BAD;
    end

    assign src_stall      = q_stat.full;
    assign push           = src_valid && !q_stat.full;
    assign push_word.ch   = src_word.src_byte;
    assign push_word.cls  = cls;
    assign push_word.eos  = src_word.end_of_source;

endmodule

// ===== hdl/sbt_queue.sv =====
// sbt_queue: short fifo of classified words between front and back
// depends on sbt_pkg

module sbt_queue
    import sbt_pkg::*;
#(
    parameter int DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  cls_word_t push_word,
    input  logic      pop,
    output cls_word_t head_word,
    output q_status_t q_stat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cls_word_t        mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_word;
    end

    assign head_word    = mem_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == CNT_W'(DEPTH));
    assign q_stat.empty = (count_reg == '0);

endmodule

// ===== hdl/sbt_back.sv =====
// sbt_back: scanner state machine and result word buffer
// depends on sbt_pkg; takes classified words from sbt_queue

module sbt_back
    import sbt_pkg::*;
#(
    parameter int MAX_TOKEN_CHARS = DEF_MAX_TOKEN_CHARS,
    parameter int MAX_TOKENS      = DEF_MAX_TOKENS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  q_status_t                q_stat,
    input  cls_word_t                head_word,
    output logic                     pop,
    input  logic [TOKEN_LIMIT_W-1:0] token_limit,
    output logic                     res_valid,
    input  logic                     res_stall,
    output res_word_t                res_word
);

    localparam int CNT_W = $clog2(MAX_TOKENS + 1);
    localparam int CH_W  = $clog2(MAX_TOKEN_CHARS);

    scan_mode_t       mode_reg, mode_next;
    logic [CNT_W-1:0] seen_reg, seen_next;
    logic [CH_W-1:0]  chars_reg, chars_next;
    token_kind_t      kind_reg, kind_next;

    res_word_t [RUN_MAX-1:0] step_res;
    logic [RUN_W-1:0]        step_n;

    res_word_t [RUN_MAX-1:0] buf_reg, buf_next;
    logic [RUN_W-1:0]        rem_reg, rem_next;
    logic                    take;

    function automatic logic at_limit(input logic [CNT_W-1:0] cnt,
                                      input logic [TOKEN_LIMIT_W-1:0] lim);
        at_limit = (32'(cnt) >= 32'(lim)) || (32'(cnt) >= 32'(MAX_TOKENS));
    endfunction

    function automatic res_word_t mk(input event_kind_t ev, input token_kind_t kd,
                                     input logic [7:0] ch, input logic first,
                                     input logic closes, input error_code_t err,
                                     input logic [TOKEN_COUNT_W-1:0] cnt);
        res_word_t w;
        w.event_kind   = ev;
        w.token_kind   = kd;
        w.token_char   = ch;
        w.is_first     = first;
        w.closes_token = closes;
        w.error_code   = err;
        w.token_count  = cnt;
        w.last_of_run  = 1'b0;
        return w;
    endfunction

    // next state and the results of the word at the head of the queue
    always_comb
    begin : scan_step
        scan_mode_t       m;
        logic [CNT_W-1:0] ts;
        logic [CH_W-1:0]  nc;
        token_kind_t      kd;
        logic             do_sym;
        logic             do_start;
        logic             is_delim;
        logic [RUN_W-1:0] n;
        logic [RUN_W-1:0] idx;
        res_word_t [RUN_MAX-1:0] r;

        m        = mode_reg;
        ts       = seen_reg;
        nc       = chars_reg;
        kd       = kind_reg;
        do_sym   = 1'b0;
        do_start = 1'b0;
        n        = '0;
        r        = '0;
        is_delim = head_word.cls inside {CC_SPACE, CC_NEWLINE, CC_LPAREN, CC_RPAREN, CC_QUOTE};

        if (head_word.eos)
        begin
            case (m)
                SM_SYM:
                begin
                    r[n[1:0]] = mk(EV_CLOSE, kd, 8'd0, 1'b0, 1'b0, ERR_UNCLOSED, '0);
                    n = n + RUN_W'(1);
                    ts = ts + CNT_W'(1);
                end
                SM_STR:
                begin
                    r[n[1:0]] = mk(EV_ERROR, TK_LPAREN, 8'd0, 1'b0, 1'b0, ERR_UNCLOSED, '0);
                    n = n + RUN_W'(1);
                end
                SM_SLASH:
                begin
                    if (at_limit(ts, token_limit))
                    begin
                        r[n[1:0]] = mk(EV_ERROR, TK_LPAREN, 8'd0, 1'b0, 1'b0, ERR_TOO_MANY, '0);
                        n = n + RUN_W'(1);
                    end
                    else
                    begin
                        r[n[1:0]] = mk(EV_BYTE, TK_SYMBOL, CH_SLASH, 1'b1, 1'b0,
                                       ERR_UNCLOSED, '0);
                        n = n + RUN_W'(1);
                        r[n[1:0]] = mk(EV_CLOSE, TK_SYMBOL, 8'd0, 1'b0, 1'b0, ERR_UNCLOSED, '0);
                        n = n + RUN_W'(1);
                        ts = ts + CNT_W'(1);
                    end
                end
                default:
                begin
                end
            endcase
            r[n[1:0]] = mk(EV_DONE, TK_LPAREN, 8'd0, 1'b0, 1'b0, ERR_UNCLOSED,
                           TOKEN_COUNT_W'(ts));
            n  = n + RUN_W'(1);
            m  = SM_IDLE;
            ts = '0;
            nc = '0;
            kd = TK_LPAREN;
        end
        else
        begin
            case (m)
                SM_SYM:
                    do_sym = 1'b1;
                SM_STR:
                begin
                    if (head_word.cls == CC_QUOTE)
                    begin
                        r[n[1:0]] = mk(EV_BYTE, TK_STRING, head_word.ch, 1'b0, 1'b1,
                                       ERR_UNCLOSED, '0);
                        n  = n + RUN_W'(1);
                        ts = ts + CNT_W'(1);
                        nc = '0;
                        m  = SM_IDLE;
                    end
                    else if (nc >= CH_W'(MAX_TOKEN_CHARS - 1))
                    begin
                        r[n[1:0]] = mk(EV_ERROR, TK_LPAREN, 8'd0, 1'b0, 1'b0,
                                       ERR_STRING_LONG, '0);
                        n  = n + RUN_W'(1);
                        nc = '0;
                        m  = SM_FAILED;
                    end
                    else
                    begin
                        r[n[1:0]] = mk(EV_BYTE, TK_STRING, head_word.ch, 1'b0, 1'b0,
                                       ERR_UNCLOSED, '0);
                        n  = n + RUN_W'(1);
                        nc = nc + CH_W'(1);
                    end
                end
                SM_SLASH:
                begin
                    if (head_word.cls == CC_SLASH)
                        m = SM_COMMENT;
                    else if (at_limit(ts, token_limit))
                    begin
                        r[n[1:0]] = mk(EV_ERROR, TK_LPAREN, 8'd0, 1'b0, 1'b0, ERR_TOO_MANY, '0);
                        n  = n + RUN_W'(1);
                        nc = '0;
                        m  = SM_FAILED;
                    end
                    else
                    begin
                        // held slash becomes the first byte of a symbol
                        r[n[1:0]] = mk(EV_BYTE, TK_SYMBOL, CH_SLASH, 1'b1, 1'b0,
                                       ERR_UNCLOSED, '0);
                        n      = n + RUN_W'(1);
                        kd     = TK_SYMBOL;
                        nc     = CH_W'(1);
                        m      = SM_SYM;
                        do_sym = 1'b1;
                    end
                end
                SM_COMMENT:
                begin
                    if (head_word.cls == CC_NEWLINE)
                        m = SM_IDLE;
                end
                SM_FAILED:
                begin
                end
                default:
                begin
                    m        = SM_IDLE;
                    do_start = 1'b1;
                end
            endcase

            if (do_sym)
            begin
                if (is_delim)
                begin
                    r[n[1:0]] = mk(EV_CLOSE, kd, 8'd0, 1'b0, 1'b0, ERR_UNCLOSED, '0);
                    n        = n + RUN_W'(1);
                    ts       = ts + CNT_W'(1);
                    nc       = '0;
                    m        = SM_IDLE;
                    do_start = 1'b1;
                end
                else if (nc >= CH_W'(MAX_TOKEN_CHARS - 1))
                begin
                    r[n[1:0]] = mk(EV_ERROR, TK_LPAREN, 8'd0, 1'b0, 1'b0, ERR_TOKEN_LONG, '0);
                    n  = n + RUN_W'(1);
                    nc = '0;
                    m  = SM_FAILED;
                end
                else
                begin
                    r[n[1:0]] = mk(EV_BYTE, kd, head_word.ch, 1'b0, 1'b0, ERR_UNCLOSED, '0);
                    n  = n + RUN_W'(1);
                    nc = nc + CH_W'(1);
                end
            end

            if (do_start)
            begin
                case (head_word.cls)
                    CC_SPACE, CC_NEWLINE:
                    begin
                    end
                    CC_SLASH:
                        m = SM_SLASH;
                    CC_BAD:
                    begin
                        r[n[1:0]] = mk(EV_ERROR, TK_LPAREN, 8'd0, 1'b0, 1'b0, ERR_UNKNOWN, '0);
                        n  = n + RUN_W'(1);
                        nc = '0;
                        m  = SM_FAILED;
                    end
                    default:
                    begin
                        if (at_limit(ts, token_limit))
                        begin
                            r[n[1:0]] = mk(EV_ERROR, TK_LPAREN, 8'd0, 1'b0, 1'b0,
                                           ERR_TOO_MANY, '0);
                            n  = n + RUN_W'(1);
                            nc = '0;
                            m  = SM_FAILED;
                        end
                        else if (head_word.cls == CC_LPAREN || head_word.cls == CC_RPAREN)
                        begin
                            r[n[1:0]] = mk(EV_BYTE,
                                           (head_word.cls == CC_LPAREN) ? TK_LPAREN : TK_RPAREN,
                                           head_word.ch, 1'b1, 1'b1, ERR_UNCLOSED, '0);
                            n  = n + RUN_W'(1);
                            ts = ts + CNT_W'(1);
                        end
                        else if (head_word.cls == CC_QUOTE)
                        begin
                            r[n[1:0]] = mk(EV_BYTE, TK_STRING, head_word.ch, 1'b1, 1'b0,
                                           ERR_UNCLOSED, '0);
                            n  = n + RUN_W'(1);
                            kd = TK_STRING;
                            nc = '0;
                            m  = SM_STR;
                        end
                        else
                        begin
                            kd = (head_word.cls == CC_DIGIT) ? TK_NUMBER : TK_SYMBOL;
                            r[n[1:0]] = mk(EV_BYTE, kd, head_word.ch, 1'b1, 1'b0,
                                           ERR_UNCLOSED, '0);
                            n  = n + RUN_W'(1);
                            nc = CH_W'(1);
                            m  = SM_SYM;
                        end
                    end
                endcase
            end
        end

        if (n != '0)
        begin
            idx = n - RUN_W'(1);
            r[idx[1:0]].last_of_run = 1'b1;
        end

        mode_next  = m;
        seen_next  = ts;
        chars_next = nc;
        kind_next  = kd;
        step_res   = r;
        step_n     = n;
    end

    // result buffer: drains one word a cycle while res_stall is low, refills as the last word leaves
    always_comb
    begin
        take     = res_valid && !res_stall;
        pop      = !q_stat.empty && ((rem_reg == '0) || ((rem_reg == RUN_W'(1)) && take));
        buf_next = buf_reg;
        rem_next = rem_reg;
        if (pop)
        begin
            buf_next = step_res;
            rem_next = step_n;
        end
        else if (take)
        begin
            for (int i = 0; i < RUN_MAX - 1; i++)
                buf_next[i] = buf_reg[i+1];
            rem_next = rem_reg - RUN_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= SM_IDLE;
            seen_reg  <= '0;
            chars_reg <= '0;
            kind_reg  <= TK_LPAREN;
            rem_reg   <= '0;
        end
        else
        begin
            if (pop)
            begin
                mode_reg  <= mode_next;
                seen_reg  <= seen_next;
                chars_reg <= chars_next;
                kind_reg  <= kind_next;
            end
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

    assign res_valid = (rem_reg != '0);
    assign res_word  = buf_reg[0];

endmodule

// ===== hdl/sexpr_byte_tokenizer_unit.sv =====
// sexpr_byte_tokenizer_unit: top level of the s-expression tokenizer
// depends on sbt_pkg, sbt_front, sbt_queue and sbt_back
//
//  channel   direction  handshake                payload
//  src       in         src_valid / src_stall    src_word   (src_word_t)
//  res       out        res_valid / res_stall    res_word   (res_word_t)
//  cfg       in         cfg_we                   cfg_wdata  (token limit)
//
// one source word a cycle while each word gives at most one result word and res_stall is low
// a word that gives k result words holds the scanner until its last result word leaves: the
// result buffer drains one word a cycle while res_stall is low and reloads as its last word leaves
// words that give no result (whitespace, comment bytes) leave the buffer empty and hold nothing up
// reset clears scanner state, queue and buffer at once; no clearing pass
// src_stall follows the queue fill only, so a stalled result side fills
// the queue and then holds the source side

module sexpr_byte_tokenizer_unit
    import sbt_pkg::*;
#(
    parameter int MAX_TOKEN_CHARS = DEF_MAX_TOKEN_CHARS,
    parameter int MAX_TOKENS      = DEF_MAX_TOKENS,
    parameter int QUEUE_DEPTH     = DEF_QUEUE_DEPTH
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     src_valid,
    output logic                     src_stall,
    input  src_word_t                src_word,
    output logic                     res_valid,
    input  logic                     res_stall,
    output res_word_t                res_word,
    input  logic                     cfg_we,
    input  logic [TOKEN_LIMIT_W-1:0] cfg_wdata
);

    // token limit register, kept across texts
    logic [TOKEN_LIMIT_W-1:0] token_limit_reg;

    // front to queue
    logic      push;
    cls_word_t push_word;

    // queue to back
    cls_word_t head_word;
    q_status_t q_stat;
    logic      pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            token_limit_reg <= TOKEN_LIMIT_RESET;
        else if (cfg_we)
            token_limit_reg <= cfg_wdata;
    end

    // classify each byte on the way in
    sbt_front u_front (
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_word  (src_word),
        .q_stat    (q_stat),
        .push      (push),
        .push_word (push_word)
    );

    // decouples intake from the scanner
    sbt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .pop       (pop),
        .head_word (head_word),
        .q_stat    (q_stat)
    );

    // scanner and result buffer
    sbt_back #(
        .MAX_TOKEN_CHARS (MAX_TOKEN_CHARS),
        .MAX_TOKENS      (MAX_TOKENS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_stat      (q_stat),
        .head_word   (head_word),
        .pop         (pop),
        .token_limit (token_limit_reg),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .res_word    (res_word)
    );

    // queue can never be full and empty together
    a_queue_flags: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue flags inconsistent");

    // an accepted source word is in the queue on the next edge
    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (src_valid && !src_stall) |=> !q_stat.empty)
        else $error("accepted word lost before the queue");

    // nothing pops from an empty queue
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("pop from empty queue");

    // done always closes its run
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_word.event_kind == EV_DONE) |-> res_word.last_of_run)
        else $error("done word not marked last of run");

    // limit register takes the written value
    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> token_limit_reg == $past(cfg_wdata))
        else $error("token limit write lost");

endmodule

// ===== test/token_stream_checker.sv =====
`timescale 1ns / 1ps
// token_stream_checker: watches the source, result and limit ports of the tokenizer,
// predicts every result word and compares it with what the block hands out
// depends on sbt_pkg

module token_stream_checker
    import sbt_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     src_valid,
    input  logic                     src_stall,
    input  src_word_t                src_word,
    input  logic                     res_valid,
    input  logic                     res_stall,
    input  res_word_t                res_word,
    input  logic                     cfg_we,
    input  logic [TOKEN_LIMIT_W-1:0] cfg_wdata,
    output int                       fail_count,
    output int                       pending,
    output int                       checked
);

    scan_mode_t               mode;
    logic [TOKEN_COUNT_W-1:0] seen;
    logic [6:0]               chars;
    token_kind_t              open_kind;
    logic [TOKEN_LIMIT_W-1:0] limit;
    res_word_t                run_words[$];
    res_word_t                expected_words[$];

    function automatic bit is_blank(logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic bit is_delim(logic [7:0] c);
        return is_blank(c) || c == CH_LPAREN || c == CH_RPAREN || c == CH_QUOTE;
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic bit can_open(logic [7:0] c);
        return (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_UPPER_A && c <= CH_UPPER_Z)
            || is_digit(c) || c == CH_PLUS || c == CH_MINUS || c == CH_STAR
            || c == CH_SLASH || c == CH_EQUAL || c == CH_LESS || c == CH_GREATER
            || c == CH_AMP || c == CH_BANG || c == CH_LPAREN || c == CH_RPAREN
            || c == CH_QUOTE;
    endfunction

    function automatic bit at_limit();
        int lim;
        lim = (int'(limit) > DEF_MAX_TOKENS) ? DEF_MAX_TOKENS : int'(limit);
        return int'(seen) >= lim;
    endfunction

    task automatic put_byte(token_kind_t kind, logic [7:0] ch, logic first, logic closes);
        res_word_t w;
        w = '0;
        w.event_kind   = EV_BYTE;
        w.token_kind   = kind;
        w.token_char   = ch;
        w.is_first     = first;
        w.closes_token = closes;
        run_words.push_back(w);
    endtask

    task automatic raise_error(error_code_t code);
        res_word_t w;
        w = '0;
        w.event_kind = EV_ERROR;
        w.error_code = code;
        run_words.push_back(w);
        mode  = SM_FAILED;
        chars = '0;
    endtask

    task automatic close_symbol();
        res_word_t w;
        w = '0;
        w.event_kind = EV_CLOSE;
        w.token_kind = open_kind;
        run_words.push_back(w);
        seen  = seen + 1'b1;
        chars = '0;
        mode  = SM_IDLE;
    endtask

    task automatic start_token(logic [7:0] c);
        if (is_blank(c))
            return;
        if (c == CH_SLASH)
        begin
            mode = SM_SLASH;
            return;
        end
        if (!can_open(c))
        begin
            raise_error(ERR_UNKNOWN);
            return;
        end
        if (at_limit())
        begin
            raise_error(ERR_TOO_MANY);
            return;
        end
        if (c == CH_LPAREN || c == CH_RPAREN)
        begin
            if (c == CH_LPAREN)
                put_byte(TK_LPAREN, c, 1'b1, 1'b1);
            else
                put_byte(TK_RPAREN, c, 1'b1, 1'b1);
            seen = seen + 1'b1;
        end
        else if (c == CH_QUOTE)
        begin
            put_byte(TK_STRING, c, 1'b1, 1'b0);
            open_kind = TK_STRING;
            chars     = '0;
            mode      = SM_STR;
        end
        else
        begin
            if (is_digit(c))
                open_kind = TK_NUMBER;
            else
                open_kind = TK_SYMBOL;
            put_byte(open_kind, c, 1'b1, 1'b0);
            chars = 7'd1;
            mode  = SM_SYM;
        end
    endtask

    task automatic symbol_next(logic [7:0] c);
        if (is_delim(c))
        begin
            close_symbol();
            start_token(c);
            return;
        end
        if (int'(chars) >= DEF_MAX_TOKEN_CHARS - 1)
        begin
            raise_error(ERR_TOKEN_LONG);
            return;
        end
        put_byte(open_kind, c, 1'b0, 1'b0);
        chars = chars + 1'b1;
    endtask

    // a held slash turns into the first byte of a symbol
    task automatic release_slash(output bit ok);
        ok = 1'b0;
        if (at_limit())
        begin
            raise_error(ERR_TOO_MANY);
            return;
        end
        open_kind = TK_SYMBOL;
        put_byte(TK_SYMBOL, CH_SLASH, 1'b1, 1'b0);
        chars = 7'd1;
        mode  = SM_SYM;
        ok    = 1'b1;
    endtask

    task automatic predict_tokens(src_word_t w);
        bit        ok;
        res_word_t r;
        logic [7:0] c;
        c = w.src_byte;
        run_words.delete();
        if (w.end_of_source)
        begin
            case (mode)
                SM_SYM:   close_symbol();
                SM_STR:   raise_error(ERR_UNCLOSED);
                SM_SLASH:
                begin
                    release_slash(ok);
                    if (ok)
                        close_symbol();
                end
                default: ;
            endcase
            r = '0;
            r.event_kind  = EV_DONE;
            r.token_count = seen;
            run_words.push_back(r);
            mode      = SM_IDLE;
            seen      = '0;
            chars     = '0;
            open_kind = TK_LPAREN;
        end
        else
        begin
            case (mode)
                SM_SYM: symbol_next(c);
                SM_STR:
                begin
                    if (c == CH_QUOTE)
                    begin
                        put_byte(TK_STRING, c, 1'b0, 1'b1);
                        seen  = seen + 1'b1;
                        chars = '0;
                        mode  = SM_IDLE;
                    end
                    else if (int'(chars) >= DEF_MAX_TOKEN_CHARS - 1)
                        raise_error(ERR_STRING_LONG);
                    else
                    begin
                        put_byte(TK_STRING, c, 1'b0, 1'b0);
                        chars = chars + 1'b1;
                    end
                end
                SM_SLASH:
                begin
                    if (c == CH_SLASH)
                        mode = SM_COMMENT;
                    else
                    begin
                        release_slash(ok);
                        if (ok)
                            symbol_next(c);
                    end
                end
                SM_COMMENT:
                begin
                    if (c == CH_NEWLINE)
                        mode = SM_IDLE;
                end
                SM_FAILED: ;
                default:
                begin
                    mode = SM_IDLE;
                    start_token(c);
                end
            endcase
        end
        foreach (run_words[i])
        begin
            r = run_words[i];
            r.last_of_run = (i == run_words.size() - 1);
            expected_words.push_back(r);
        end
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t mismatch in %s: expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_word_t want;
        if (!rst_n)
        begin
            mode      = SM_IDLE;
            seen      = '0;
            chars     = '0;
            open_kind = TK_LPAREN;
            limit     = TOKEN_LIMIT_RESET;
            expected_words.delete();
            fail_count = 0;
            pending    = 0;
            checked    = 0;
        end
        else
        begin
            if (cfg_we)
                limit = cfg_wdata;
            if (src_valid && !src_stall)
                predict_tokens(src_word);
            if (res_valid && !res_stall)
            begin
                checked++;
                if (expected_words.size() == 0)
                begin
                    $display("%0t result word with none expected: expected nothing, actual %h",
                             $time, res_word);
                    fail_count++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    check_field("event_kind", 32'(want.event_kind), 32'(res_word.event_kind));
                    check_field("token_kind", 32'(want.token_kind), 32'(res_word.token_kind));
                    check_field("token_char", 32'(want.token_char), 32'(res_word.token_char));
                    check_field("is_first", 32'(want.is_first), 32'(res_word.is_first));
                    check_field("closes_token", 32'(want.closes_token),
                                32'(res_word.closes_token));
                    check_field("error_code", 32'(want.error_code), 32'(res_word.error_code));
                    check_field("token_count", 32'(want.token_count),
                                32'(res_word.token_count));
                    check_field("last_of_run", 32'(want.last_of_run),
                                32'(res_word.last_of_run));
                end
            end
            pending = expected_words.size();
        end
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// testbench: source text stimulus, limit writes and verdict for sexpr_byte_tokenizer_unit
// depends on sbt_pkg, the block's rtl and token_stream_checker

module testbench;
    import sbt_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int TARGET_WORDS  = 470;
    localparam int SETTLE_CYCLES = 12;
    localparam int N_PHASES      = 7;

    localparam logic [7:0] OP_CHARS [9] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_EQUAL,
                                            CH_LESS, CH_GREATER, CH_AMP, CH_BANG};

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     src_valid = 1'b0;
    logic                     src_stall;
    src_word_t                src_word  = '0;
    logic                     res_valid;
    logic                     res_stall = 1'b1;
    res_word_t                res_word;
    logic                     cfg_we    = 1'b0;
    logic [TOKEN_LIMIT_W-1:0] cfg_wdata = '0;

    int fail_count;
    int pending;
    int checked;
    int words_sent  = 0;
    int texts_sent  = 0;
    int cycle_count = 0;

    // when set, neither side adds random gaps or stalls
    bit calm = 1'b0;

    logic [TOKEN_LIMIT_W-1:0] phase_limit [N_PHASES];

    sexpr_byte_tokenizer_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_word  (src_word),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_word  (res_word),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    token_stream_checker token_check
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .src_valid  (src_valid),
        .src_stall  (src_stall),
        .src_word   (src_word),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_word   (res_word),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // ---------------------------------------------------------------- helpers

    // one source word: optional gap with valid low, then hold until taken
    task automatic send_word(logic [7:0] ch, logic eos);
        int        gap;
        src_word_t w;
        gap = calm ? 0 : $urandom_range(0, 6);
        w.src_byte      = ch;
        w.end_of_source = eos;
        if (gap > 0)
        begin
            src_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        src_word  <= w;
        src_valid <= 1'b1;
        do @(posedge clk); while (src_stall);
        words_sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i], 1'b0);
    endtask

    // end of source; the byte riding along is meaningless, so make it random
    task automatic end_text();
        send_word(8'($urandom_range(0, 255)), 1'b1);
        texts_sent++;
    endtask

    // hold the source side until every predicted word has come back
    task automatic drain();
        src_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // whitespace and comment bytes give no result, so allow the queue to empty too
    task automatic settle();
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(logic [TOKEN_LIMIT_W-1:0] value);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [7:0] rand_blank();
        int k;
        k = $urandom_range(0, 5);
        return (k == 5) ? CH_SPACE : CH_TAB + 8'(k);
    endfunction

    function automatic logic [7:0] start_char();
        case ($urandom_range(0, 3))
            0:       return CH_LOWER_A + 8'($urandom_range(0, 25));
            1:       return CH_UPPER_A + 8'($urandom_range(0, 25));
            2:       return OP_CHARS[$urandom_range(0, 8)];
            default: return CH_ZERO + 8'($urandom_range(0, 9));
        endcase
    endfunction

    // symbol body: mostly printable, now and then any byte that is not a delimiter
    function automatic logic [7:0] tail_char();
        logic [7:0] c;
        if ($urandom_range(0, 7) != 0)
            return start_char();
        c = 8'($urandom_range(1, 255));
        if (c == CH_LPAREN || c == CH_RPAREN || c == CH_QUOTE || c == CH_SPACE
            || (c >= CH_TAB && c <= CH_CR))
            c = CH_LOWER_Z;
        return c;
    endfunction

    // string body: anything but the closing quote
    function automatic logic [7:0] text_char();
        logic [7:0] c;
        if ($urandom_range(0, 5) != 0)
            return ($urandom_range(0, 4) == 0) ? CH_SPACE : start_char();
        c = 8'($urandom_range(1, 255));
        if (c == CH_QUOTE)
            c = CH_BANG;
        return c;
    endfunction

    function automatic logic [7:0] comment_char();
        logic [7:0] c;
        c = 8'($urandom_range(1, 255));
        if (c == CH_NEWLINE)
            c = CH_SPACE;
        return c;
    endfunction

    // a text of mostly well formed tokens with random content, a little noise,
    // the odd unterminated string, and optionally one token near the length limit
    task automatic random_text(int n_tokens, int long_len);
        for (int t = 0; t < n_tokens; t++)
        begin
            // separator: whitespace, a comment line, or nothing at all
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: send_word(rand_blank(), 1'b0);
                5:
                begin
                    send_word(CH_SLASH, 1'b0);
                    send_word(CH_SLASH, 1'b0);
                    repeat ($urandom_range(0, 6)) send_word(comment_char(), 1'b0);
                    send_word(CH_NEWLINE, 1'b0);
                end
                default: ;
            endcase
            // now and then the sender waits for the result side to catch up
            if ($urandom_range(0, 39) == 0)
                drain();
            if (long_len > 0 && t == 0)
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    send_word(CH_LOWER_A + 8'($urandom_range(0, 25)), 1'b0);
                    repeat (long_len - 1) send_word(tail_char(), 1'b0);
                end
                else
                begin
                    send_word(CH_QUOTE, 1'b0);
                    repeat (long_len) send_word(text_char(), 1'b0);
                    send_word(CH_QUOTE, 1'b0);
                end
            end
            else
            begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3: send_word(CH_LPAREN, 1'b0);
                    4, 5, 6:    send_word(CH_RPAREN, 1'b0);
                    7, 8, 9:
                    begin
                        send_word(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
                        repeat ($urandom_range(0, 4)) send_word(tail_char(), 1'b0);
                    end
                    10, 11, 12, 13:
                    begin
                        send_word(start_char(), 1'b0);
                        repeat ($urandom_range(0, 5)) send_word(tail_char(), 1'b0);
                    end
                    14, 15, 16:
                    begin
                        send_word(CH_QUOTE, 1'b0);
                        repeat ($urandom_range(0, 6)) send_word(text_char(), 1'b0);
                        send_word(CH_QUOTE, 1'b0);
                    end
                    17:
                    begin
                        // a leading slash that may turn out to be a symbol or a comment
                        send_word(CH_SLASH, 1'b0);
                        repeat ($urandom_range(0, 2)) send_word(tail_char(), 1'b0);
                    end
                    18: send_word(8'($urandom_range(1, 255)), 1'b0);
                    default:
                    begin
                        // broken string, never closed
                        send_word(CH_QUOTE, 1'b0);
                        repeat ($urandom_range(0, 3)) send_word(text_char(), 1'b0);
                    end
                endcase
            end
        end
        end_text();
    endtask

    // ---------------------------------------------------------------- result side

    // random stall before each result word, none while calm
    initial
    begin
        int hold;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            hold = calm ? 0 : $urandom_range(0, 6);
            if (hold > 0)
            begin
                res_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            res_stall <= 1'b0;
            do @(posedge clk); while (!res_valid);
        end
    end

    // ---------------------------------------------------------------- watchdog

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("run stopped after %0d cycles with %0d words outstanding",
                 cycle_count, pending);
        $display("FAILURE");
        $finish;
    end

    // ---------------------------------------------------------------- stimulus

    initial
    begin
        int n_tokens;
        int long_len;
        int phase_end;

        // extremes of the limit register plus a small random one
        phase_limit = '{11'd1, 11'd0, 11'd4, 11'd2047, 11'd1024, 11'd0, 11'd1024};
        phase_limit[5] = 11'($urandom_range(2, 9));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed texts under the reset limit
        // parens, a number closed by a space, a string with its quotes
        send_text("(9a \"q\")");
        end_text();
        // comment line, slash released into a symbol, lone slash at end of source
        send_text("//\n/x /");
        end_text();
        // top byte cannot start a token; what follows is ignored
        send_word(8'hFF, 1'b0);
        send_word(CH_LPAREN, 1'b0);
        end_text();
        // end of source inside a string
        send_text("\"a");
        end_text();
        // byte zero at a token start
        send_word(8'h00, 1'b0);
        end_text();

        // random phases, each under its own limit, written only once idle;
        // the word budget runs over the whole test so the total stays near target
        for (int p = 0; p < N_PHASES; p++)
        begin
            settle();
            write_limit(phase_limit[p]);
            phase_end = (TARGET_WORDS * (p + 1)) / N_PHASES;
            long_len  = (phase_limit[p] >= 16) ? $urandom_range(62, 65) : 0;
            do
            begin
                calm = ($urandom_range(0, 3) == 0);
                // small limits get short texts so the too-many error comes early
                if (phase_limit[p] < 16)
                    n_tokens = phase_limit[p] + $urandom_range(0, 3);
                else
                    n_tokens = $urandom_range(2, 12);
                random_text(n_tokens, long_len);
                long_len = (phase_limit[p] >= 16 && $urandom_range(0, 9) == 0)
                           ? $urandom_range(62, 65) : 0;
            end
            while (words_sent < phase_end);
        end

        calm = 1'b0;
        settle();

        $display("%0d source words in %0d texts, %0d result words checked,",
                 words_sent, texts_sent, checked);
        $display("token limits 0 to 2047 with random gaps and stalls on both sides");
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
